// ===== design/hsv_to_rgb_converter_unit_defines.svh =====
// Assertion macros for the HSV to RGB converter RTL, used by hsv2rgb_product.
// Needs clk and arst_n in the scope of each use.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

// Check an expression at every clock edge out of reset.
`define HSV2RGB_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
	else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define HSV2RGB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== design/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB converter: widths, sector codes, stage payloads.
// No dependencies.
package hsv2rgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FX_W      = FRAC_BITS + 1;
	localparam int HUE6_W    = FRAC_BITS + 3;
	localparam int PROD_W    = 2 * FX_W;
	localparam int PIX_W     = 8;
	localparam int SECTORS   = 6;

	localparam logic [FX_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t               sector;
		logic [FRAC_BITS-1:0]  frac;
		logic [FX_W-1:0]       sat;
		logic [FX_W-1:0]       val;
	} front_t;

	typedef struct packed {
		sector_t               sector;
		logic [FX_W-1:0]       val;
		logic [FX_W-1:0]       omp;
		logic [FX_W-1:0]       omq;
		logic [FX_W-1:0]       omt;
	} coef_t;

	typedef struct packed {
		sector_t               sector;
		logic [FX_W-1:0]       val;
		logic [FX_W-1:0]       p;
		logic [FX_W-1:0]       q;
		logic [FX_W-1:0]       t;
	} chan_t;

endpackage

// ===== design/hsv2rgb_if.sv =====
// Valid/ready channels for HSV pixels in and RGB pixels out.
// Depends on hsv2rgb_pkg.
interface hsv2rgb_hsv_if;
	logic                              valid;
	logic                              ready;
	logic [hsv2rgb_pkg::FRAC_BITS-1:0] hue;
	logic [hsv2rgb_pkg::FX_W-1:0]      saturation;
	logic [hsv2rgb_pkg::FX_W-1:0]      brightness;

	modport source(output valid, hue, saturation, brightness, input ready);
	modport sink(input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
	logic                          valid;
	logic                          ready;
	logic [hsv2rgb_pkg::PIX_W-1:0] red;
	logic [hsv2rgb_pkg::PIX_W-1:0] green;
	logic [hsv2rgb_pkg::PIX_W-1:0] blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface

// ===== design/hsv2rgb_sector.sv =====
// First stage: clamp saturation and value, split hue into sector and fraction.
// Depends on hsv2rgb_pkg and hsv2rgb_hsv_if.
module hsv2rgb_sector (
	input  logic                clk,
	input  logic                arst_n,
	hsv2rgb_hsv_if.sink         hsv,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::front_t out_data
);

	logic                             en_s1;
	logic                             valid_s1;
	hsv2rgb_pkg::front_t              data_s1;
	logic [hsv2rgb_pkg::HUE6_W-1:0]   hue6;
	logic [hsv2rgb_pkg::FX_W-1:0]     sat;
	logic [hsv2rgb_pkg::FX_W-1:0]     val;

	assign hue6 = hsv2rgb_pkg::HUE6_W'(hsv.hue)
		* hsv2rgb_pkg::HUE6_W'(hsv2rgb_pkg::SECTORS);
	assign sat  = (hsv.saturation > hsv2rgb_pkg::ONE_FX) ? hsv2rgb_pkg::ONE_FX
		: hsv.saturation;
	assign val  = (hsv.brightness > hsv2rgb_pkg::ONE_FX) ? hsv2rgb_pkg::ONE_FX
		: hsv.brightness;

	assign en_s1     = !valid_s1 || out_ready;
	assign hsv.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= hsv.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && hsv.valid) begin
			data_s1.sector <= hsv2rgb_pkg::sector_t'(
				hue6[hsv2rgb_pkg::HUE6_W-1:hsv2rgb_pkg::FRAC_BITS]);
			data_s1.frac   <= hue6[hsv2rgb_pkg::FRAC_BITS-1:0];
			data_s1.sat    <= sat;
			data_s1.val    <= val;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== design/hsv2rgb_product.sv =====
// Second and third stages: saturation products, then p, q and t from value.
// Depends on hsv2rgb_pkg and the assertion macros.
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsv2rgb_product (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hsv2rgb_pkg::front_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output hsv2rgb_pkg::chan_t  out_data
);

	logic                             en_s2;
	logic                             en_s3;
	logic                             valid_s2;
	logic                             valid_s3;
	hsv2rgb_pkg::coef_t               data_s2;
	hsv2rgb_pkg::chan_t               data_s3;
	logic [hsv2rgb_pkg::FX_W-1:0]     one_m_f;
	logic [hsv2rgb_pkg::PROD_W-1:0]   sf_prod;
	logic [hsv2rgb_pkg::PROD_W-1:0]   sfn_prod;
	logic [hsv2rgb_pkg::PROD_W-1:0]   p_prod;
	logic [hsv2rgb_pkg::PROD_W-1:0]   q_prod;
	logic [hsv2rgb_pkg::PROD_W-1:0]   t_prod;

	assign one_m_f  = hsv2rgb_pkg::ONE_FX - hsv2rgb_pkg::FX_W'(in_data.frac);
	assign sf_prod  = hsv2rgb_pkg::PROD_W'(in_data.sat)
		* hsv2rgb_pkg::PROD_W'(in_data.frac);
	assign sfn_prod = hsv2rgb_pkg::PROD_W'(in_data.sat)
		* hsv2rgb_pkg::PROD_W'(one_m_f);

	assign p_prod = hsv2rgb_pkg::PROD_W'(data_s2.val) * hsv2rgb_pkg::PROD_W'(data_s2.omp);
	assign q_prod = hsv2rgb_pkg::PROD_W'(data_s2.val) * hsv2rgb_pkg::PROD_W'(data_s2.omq);
	assign t_prod = hsv2rgb_pkg::PROD_W'(data_s2.val) * hsv2rgb_pkg::PROD_W'(data_s2.omt);

	assign en_s3    = !valid_s3 || out_ready;
	assign en_s2    = !valid_s2 || en_s3;
	assign in_ready = en_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= in_valid;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			data_s2.sector <= in_data.sector;
			data_s2.val    <= in_data.val;
			data_s2.omp    <= hsv2rgb_pkg::ONE_FX - in_data.sat;
			data_s2.omq    <= hsv2rgb_pkg::ONE_FX
				- sf_prod[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::FX_W];
			data_s2.omt    <= hsv2rgb_pkg::ONE_FX
				- sfn_prod[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::FX_W];
		end
		if (en_s3 && valid_s2) begin
			data_s3.sector <= data_s2.sector;
			data_s3.val    <= data_s2.val;
			data_s3.p      <= p_prod[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::FX_W];
			data_s3.q      <= q_prod[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::FX_W];
			data_s3.t      <= t_prod[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::FX_W];
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	`HSV2RGB_ASSERT(a_sector_range, !valid_s2 || data_s2.sector <= hsv2rgb_pkg::SEC_MR, "sector out of range")
	`HSV2RGB_ASSERT(a_coef_bound, !valid_s2 || (data_s2.omp <= hsv2rgb_pkg::ONE_FX && data_s2.omq <= hsv2rgb_pkg::ONE_FX && data_s2.omt <= hsv2rgb_pkg::ONE_FX), "coefficient above one")
	`HSV2RGB_ASSERT(a_chan_bound, !valid_s3 || (data_s3.p <= data_s3.val && data_s3.q <= data_s3.val && data_s3.t <= data_s3.val), "channel above value")
	`HSV2RGB_ASSERT_NEXT(a_s3_hold, valid_s3 && !out_ready, valid_s3 && $stable(data_s3), "stage three lost a stalled beat")

endmodule

// ===== design/hsv2rgb_route.sv =====
// Last stage: route v, p, q, t to channels by sector, scale by 255, register output.
// Depends on hsv2rgb_pkg and hsv2rgb_rgb_if.
module hsv2rgb_route (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  hsv2rgb_pkg::chan_t in_data,
	hsv2rgb_rgb_if.source      rgb
);

	localparam int SCL_W = hsv2rgb_pkg::FX_W + hsv2rgb_pkg::PIX_W;

	logic                            en_s4;
	logic                            valid_s4;
	logic [hsv2rgb_pkg::PIX_W-1:0]   red_s4;
	logic [hsv2rgb_pkg::PIX_W-1:0]   green_s4;
	logic [hsv2rgb_pkg::PIX_W-1:0]   blue_s4;
	logic [hsv2rgb_pkg::FX_W-1:0]    r_x;
	logic [hsv2rgb_pkg::FX_W-1:0]    g_x;
	logic [hsv2rgb_pkg::FX_W-1:0]    b_x;
	logic [SCL_W-1:0]                r_scl;
	logic [SCL_W-1:0]                g_scl;
	logic [SCL_W-1:0]                b_scl;

	always_comb begin
		case (in_data.sector)
			hsv2rgb_pkg::SEC_RY: begin
				r_x = in_data.val; g_x = in_data.t;   b_x = in_data.p;
			end
			hsv2rgb_pkg::SEC_YG: begin
				r_x = in_data.q;   g_x = in_data.val; b_x = in_data.p;
			end
			hsv2rgb_pkg::SEC_GC: begin
				r_x = in_data.p;   g_x = in_data.val; b_x = in_data.t;
			end
			hsv2rgb_pkg::SEC_CB: begin
				r_x = in_data.p;   g_x = in_data.q;   b_x = in_data.val;
			end
			hsv2rgb_pkg::SEC_BM: begin
				r_x = in_data.t;   g_x = in_data.p;   b_x = in_data.val;
			end
			default: begin
				r_x = in_data.val; g_x = in_data.p;   b_x = in_data.q;
			end
		endcase
	end

	// x * 255 as (x << 8) - x
	assign r_scl = {r_x, {hsv2rgb_pkg::PIX_W{1'b0}}} - SCL_W'(r_x);
	assign g_scl = {g_x, {hsv2rgb_pkg::PIX_W{1'b0}}} - SCL_W'(g_x);
	assign b_scl = {b_x, {hsv2rgb_pkg::PIX_W{1'b0}}} - SCL_W'(b_x);

	assign en_s4    = !valid_s4 || rgb.ready;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en_s4) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			red_s4   <= r_scl[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::PIX_W];
			green_s4 <= g_scl[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::PIX_W];
			blue_s4  <= b_scl[hsv2rgb_pkg::FRAC_BITS +: hsv2rgb_pkg::PIX_W];
		end
	end

	assign rgb.valid = valid_s4;
	assign rgb.red   = red_s4;
	assign rgb.green = green_s4;
	assign rgb.blue  = blue_s4;

endmodule

// ===== design/hsv_to_rgb_converter_unit.sv =====
// HSV to RGB converter, top level.
// Depends on hsv2rgb_pkg, the channel interfaces, and the three stage modules.
//
// Usage:
//   hsv carries one HSV pixel per beat: hue as a fraction of a turn, saturation
//   and brightness in 1.16 fixed point (values above one clamp to one).
//   rgb carries one 8-bit RGB pixel per beat, in the order the pixels came in.
//   A beat is taken at a clock edge where valid and ready are both high.
//   A pixel passes the sector, product and route stage registers in order.
//   Throughput: one pixel per cycle while rgb is ready; four register stages,
//   each with its own valid bit, one 17x17 multiply bank per multiply stage.
//   When rgb stalls, the output register holds its beat; upstream stages keep
//   filling empty slots, and hsv.ready drops only when every stage is full.
//   Reset (arst_n low) clears all valid bits; the data registers are not reset.
module hsv_to_rgb_converter_unit (
	input  logic          clk,
	input  logic          arst_n,
	hsv2rgb_hsv_if.sink   hsv,
	hsv2rgb_rgb_if.source rgb
);

	logic                front_valid;
	logic                front_ready;
	hsv2rgb_pkg::front_t front_data;
	logic                chan_valid;
	logic                chan_ready;
	hsv2rgb_pkg::chan_t  chan_data;

	hsv2rgb_sector u_sector (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv       (hsv),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	hsv2rgb_product u_product (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (chan_valid),
		.out_ready (chan_ready),
		.out_data  (chan_data)
	);

	hsv2rgb_route u_route (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chan_valid),
		.in_ready (chan_ready),
		.in_data  (chan_data),
		.rgb      (rgb)
	);

endmodule

// ===== dv/hsv_to_rgb_converter_unit_checker.sv =====
// Scoreboard for the HSV to RGB converter: predicts each RGB pixel from the
// accepted HSV beats and compares it field by field with the rgb beats.
// Depends on hsv2rgb_pkg and the channel interfaces in hsv2rgb_if.sv.
module hsv_to_rgb_converter_unit_checker (
	input  logic   clk,
	input  logic   arst_n,
	hsv2rgb_hsv_if hsv,
	hsv2rgb_rgb_if rgb,
	output int     fails,
	output int     pending
);
	import hsv2rgb_pkg::*;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_pix_t;

	rgb_pix_t pixel_q[$];
	int       fail_cnt = 0;
	int       pend_cnt = 0;

	assign fails   = fail_cnt;
	assign pending = pend_cnt;

	function automatic logic [PIX_W-1:0] scale_to_byte(input logic [63:0] x);
		logic [63:0] scaled;
		scaled = (x * 64'd255) >> FRAC_BITS;
		return scaled[PIX_W-1:0];
	endfunction

	function automatic rgb_pix_t hsv_to_rgb_pixel(
		input logic [FRAC_BITS-1:0] hue,
		input logic [FX_W-1:0]      sat_in,
		input logic [FX_W-1:0]      val_in
	);
		logic [FX_W-1:0]      s;
		logic [FX_W-1:0]      v;
		logic [HUE6_W-1:0]    h6;
		logic [FRAC_BITS-1:0] f;
		logic [63:0]          p, q, t, vv;
		rgb_pix_t             pix;
		s  = (sat_in > ONE_FX) ? ONE_FX : sat_in;
		v  = (val_in > ONE_FX) ? ONE_FX : val_in;
		h6 = HUE6_W'(hue) * HUE6_W'(SECTORS);
		f  = h6[FRAC_BITS-1:0];
		vv = 64'(v);
		p  = (vv * (64'(ONE_FX) - 64'(s))) >> FRAC_BITS;
		q  = (vv * (64'(ONE_FX) - ((64'(s) * 64'(f)) >> FRAC_BITS))) >> FRAC_BITS;
		t  = (vv * (64'(ONE_FX) - ((64'(s) * (64'(ONE_FX) - 64'(f))) >> FRAC_BITS)))
			>> FRAC_BITS;
		case (sector_t'(h6[HUE6_W-1:FRAC_BITS]))
			SEC_RY: begin
				pix = {scale_to_byte(vv), scale_to_byte(t), scale_to_byte(p)};
			end
			SEC_YG: begin
				pix = {scale_to_byte(q), scale_to_byte(vv), scale_to_byte(p)};
			end
			SEC_GC: begin
				pix = {scale_to_byte(p), scale_to_byte(vv), scale_to_byte(t)};
			end
			SEC_CB: begin
				pix = {scale_to_byte(p), scale_to_byte(q), scale_to_byte(vv)};
			end
			SEC_BM: begin
				pix = {scale_to_byte(t), scale_to_byte(p), scale_to_byte(vv)};
			end
			default: begin
				pix = {scale_to_byte(vv), scale_to_byte(p), scale_to_byte(q)};
			end
		endcase
		return pix;
	endfunction

	always @(posedge clk) begin
		rgb_pix_t want;
		if (arst_n) begin
			if (rgb.valid && rgb.ready) begin
				if (pixel_q.size() == 0) begin
					$error("rgb beat with no pixel pending: red %0d green %0d blue %0d",
						rgb.red, rgb.green, rgb.blue);
					fail_cnt++;
				end else begin
					want = pixel_q.pop_front();
					if (rgb.red !== want.red) begin
						$error("red: expected %0d, actual %0d", want.red, rgb.red);
						fail_cnt++;
					end
					if (rgb.green !== want.green) begin
						$error("green: expected %0d, actual %0d", want.green, rgb.green);
						fail_cnt++;
					end
					if (rgb.blue !== want.blue) begin
						$error("blue: expected %0d, actual %0d", want.blue, rgb.blue);
						fail_cnt++;
					end
				end
			end
			if (hsv.valid && hsv.ready) begin
				pixel_q.push_back(hsv_to_rgb_pixel(hsv.hue, hsv.saturation, hsv.brightness));
			end
			pend_cnt <= pixel_q.size();
		end
	end

endmodule

// ===== dv/hsv_to_rgb_converter_unit_tb.sv =====
// Testbench top for hsv_to_rgb_converter_unit: drives HSV beats and random rgb
// stalls, and gives the verdict from the checker's failure and pending counts.
// Depends on hsv2rgb_pkg, hsv2rgb_if.sv and hsv_to_rgb_converter_unit_checker.
module hsv_to_rgb_converter_unit_tb;
	import hsv2rgb_pkg::*;

	localparam int N_RANDOM = 500;
	localparam int MAX_WAIT = 13;
	localparam int HUE_STEP = 10923;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	bit   tx_idle = 1'b1;
	bit   rx_idle = 1'b1;

	hsv2rgb_hsv_if hsv_ch ();
	hsv2rgb_rgb_if rgb_ch ();

	hsv_to_rgb_converter_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	hsv_to_rgb_converter_unit_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.hsv     (hsv_ch),
		.rgb     (rgb_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_pixel(
		input logic [FRAC_BITS-1:0] hue,
		input logic [FX_W-1:0]      sat,
		input logic [FX_W-1:0]      val
	);
		int gap;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			hsv_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hsv_ch.valid      <= 1'b1;
		hsv_ch.hue        <= hue;
		hsv_ch.saturation <= sat;
		hsv_ch.brightness <= val;
		do @(posedge clk); while (!hsv_ch.ready);
	endtask

	task automatic drain_pixels();
		hsv_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	function automatic logic [FX_W-1:0] pick_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ONE_FX;
			2: return ONE_FX - 1'b1;
			3: return ONE_FX + 1'b1;
			4: return '1;
			5: return FX_W'($urandom_range(0, (1 << FX_W) - 1));
			default: return FX_W'($urandom_range(0, ONE_FX));
		endcase
	endfunction

	initial begin
		rgb_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			if ($urandom_range(0, 47) == 0) begin
				rx_idle = !rx_idle;
			end
			stall = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				rgb_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rgb_ch.ready <= 1'b1;
			do @(posedge clk); while (!rgb_ch.valid);
		end
	end

	initial begin
		logic [FRAC_BITS-1:0] hue;
		arst_n            <= 1'b0;
		hsv_ch.valid      <= 1'b0;
		hsv_ch.hue        <= '0;
		hsv_ch.saturation <= '0;
		hsv_ch.brightness <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel('0, ONE_FX, ONE_FX);
		send_pixel('1, ONE_FX, ONE_FX);
		for (int k = 1; k < SECTORS; k++) begin
			send_pixel(FRAC_BITS'(k * HUE_STEP - 1), ONE_FX, ONE_FX);
			send_pixel(FRAC_BITS'(k * HUE_STEP), ONE_FX, ONE_FX);
		end
		send_pixel(16'h1234, '0, ONE_FX);
		send_pixel(16'h9abc, ONE_FX, '0);
		send_pixel(16'h5555, '0, '0);
		send_pixel(16'h2000, '1, '1);
		send_pixel(16'hc000, ONE_FX + 1'b1, ONE_FX + 1'b1);
		send_pixel(16'h7777, ONE_FX - 1'b1, ONE_FX - 1'b1);
		send_pixel('1, 17'h0ffff, '1);
		send_pixel(16'h8000, 17'h10000, 17'h0aaaa);
		drain_pixels();

		for (int n = 0; n < N_RANDOM; n++) begin
			if ($urandom_range(0, 39) == 0) begin
				tx_idle = !tx_idle;
			end
			if (n == N_RANDOM / 2) begin
				drain_pixels();
			end
			case ($urandom_range(0, 9))
				0: begin
					send_pixel(FRAC_BITS'($urandom), FX_W'($urandom), FX_W'($urandom));
				end
				1, 2: begin
					hue = FRAC_BITS'($urandom_range(0, SECTORS) * HUE_STEP
						- $urandom_range(0, 1));
					send_pixel(hue, pick_level(), pick_level());
				end
				default: begin
					send_pixel(FRAC_BITS'($urandom), FX_W'($urandom_range(0, ONE_FX)),
						FX_W'($urandom_range(0, ONE_FX)));
				end
			endcase
		end
		drain_pixels();
		repeat (10) @(posedge clk);

		if (fails == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/hsv2rgb_pkg.sv
design/hsv2rgb_if.sv
design/hsv2rgb_sector.sv
design/hsv2rgb_product.sv
design/hsv2rgb_route.sv
design/hsv_to_rgb_converter_unit.sv
dv/hsv_to_rgb_converter_unit_checker.sv
dv/hsv_to_rgb_converter_unit_tb.sv
